@@ hw/rtl/aric_pkg.sv @@
`timescale 1ns / 1ps

package aric_pkg;

  // fixed field widths
  localparam int unsigned WORD_W = 32;
  localparam int unsigned IV_W   = 15;
  localparam int unsigned INC_W  = 15;
  localparam int unsigned DEC_W  = 14;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // error word layout
  localparam int unsigned RANK1_OVF_BIT = 31;
  localparam int unsigned RANK1_LSB     = 16;
  localparam int unsigned RANK0_OVF_BIT = 15;
  localparam int unsigned RANK0_LSB     = 0;

  localparam logic [IV_W-1:0] IV_MAX = 15'h7fff;

  // register reset values
  localparam logic [INC_W-1:0] INC_STEP_RST = 15'd16;
  localparam logic [DEC_W-1:0] DEC_STEP_RST = 14'd16;
  localparam logic [IV_W-1:0]  MAX_IV_RST   = 15'h71c0;
  localparam logic [IV_W-1:0]  MIN_IV_RST   = 15'd0;

  typedef enum logic [1:0] {
    REG_INC_STEP = 2'd0,
    REG_DEC_STEP = 2'd1,
    REG_MAX_IV   = 2'd2,
    REG_MIN_IV   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [INC_W-1:0] inc_step;
    logic [DEC_W-1:0] dec_step;
    logic [IV_W-1:0]  max_iv;
    logic [IV_W-1:0]  min_iv;
  } cfg_t;

  typedef struct packed {
    logic rank1;
    logic rank0;
  } flags_t;

endpackage

@@ hw/rtl/aric_cfg_regs.sv @@
`timescale 1ns / 1ps

module aric_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [aric_pkg::ADDR_W-1:0]  paddr,
  input  logic [aric_pkg::DATA_W-1:0]  pwdata,
  output logic [aric_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output aric_pkg::cfg_t               cfg_o
);

  aric_pkg::cfg_t     cfg_q;
  aric_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = aric_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inc_step <= aric_pkg::INC_STEP_RST;
      cfg_q.dec_step <= aric_pkg::DEC_STEP_RST;
      cfg_q.max_iv   <= aric_pkg::MAX_IV_RST;
      cfg_q.min_iv   <= aric_pkg::MIN_IV_RST;
    end else if (wr_en) begin
      case (idx)
        aric_pkg::REG_INC_STEP: cfg_q.inc_step <= pwdata[aric_pkg::INC_W-1:0];
        aric_pkg::REG_DEC_STEP: cfg_q.dec_step <= pwdata[aric_pkg::DEC_W-1:0];
        aric_pkg::REG_MAX_IV:   cfg_q.max_iv   <= pwdata[aric_pkg::IV_W-1:0];
        aric_pkg::REG_MIN_IV:   cfg_q.min_iv   <= pwdata[aric_pkg::IV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      aric_pkg::REG_INC_STEP:
        prdata = {{(aric_pkg::DATA_W-aric_pkg::INC_W){1'b0}}, cfg_q.inc_step};
      aric_pkg::REG_DEC_STEP:
        prdata = {{(aric_pkg::DATA_W-aric_pkg::DEC_W){1'b0}}, cfg_q.dec_step};
      aric_pkg::REG_MAX_IV:
        prdata = {{(aric_pkg::DATA_W-aric_pkg::IV_W){1'b0}}, cfg_q.max_iv};
      aric_pkg::REG_MIN_IV:
        prdata = {{(aric_pkg::DATA_W-aric_pkg::IV_W){1'b0}}, cfg_q.min_iv};
      default:
        prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/aric_chan_state.sv @@
`timescale 1ns / 1ps

module aric_chan_state #(
  parameter int unsigned NUM_CHANNELS = 4,
  parameter int unsigned COUNT_BITS   = 15,
  localparam int unsigned PTR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  upd_i,
  input  logic [COUNT_BITS-1:0] cnt1_i,
  input  logic [COUNT_BITS-1:0] cnt0_i,
  input  aric_pkg::flags_t      flags_i,
  output logic [PTR_W-1:0]      ch_o,
  output logic [COUNT_BITS-1:0] cnt1_o,
  output logic [COUNT_BITS-1:0] cnt0_o,
  output aric_pkg::flags_t      flags_o
);

  logic [PTR_W-1:0]      ptr_q;
  logic [COUNT_BITS-1:0] cnt1_q [NUM_CHANNELS];
  logic [COUNT_BITS-1:0] cnt0_q [NUM_CHANNELS];
  aric_pkg::flags_t      flags_q [NUM_CHANNELS];

  assign ch_o    = ptr_q;
  assign cnt1_o  = cnt1_q[ptr_q];
  assign cnt0_o  = cnt0_q[ptr_q];
  assign flags_o = flags_q[ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        cnt1_q[i]  <= '0;
        cnt0_q[i]  <= '0;
        flags_q[i] <= '0;
      end
    end else if (upd_i) begin
      cnt1_q[ptr_q]  <= cnt1_i;
      cnt0_q[ptr_q]  <= cnt0_i;
      flags_q[ptr_q] <= flags_i;
      // round robin wrap
      ptr_q <= (ptr_q == PTR_W'(NUM_CHANNELS - 1)) ? '0 : ptr_q + 1'b1;
    end
  end

endmodule

@@ hw/rtl/aric_update.sv @@
`timescale 1ns / 1ps

module aric_update #(
  parameter int unsigned COUNT_BITS = 15
) (
  input  aric_pkg::cfg_t                  cfg_i,
  input  logic [aric_pkg::WORD_W-1:0]     word_i,
  input  logic [aric_pkg::IV_W-1:0]       iv_i,
  input  logic [COUNT_BITS-1:0]           prev1_i,
  input  logic [COUNT_BITS-1:0]           prev0_i,
  input  aric_pkg::flags_t                flags_i,
  output logic [COUNT_BITS-1:0]           cnt1_o,
  output logic [COUNT_BITS-1:0]           cnt0_o,
  output aric_pkg::flags_t                flags_o,
  output logic [aric_pkg::IV_W-1:0]       iv_o,
  output logic                            err_o
);

  localparam int unsigned IVW = aric_pkg::IV_W;

  logic            ovf1, ovf0, clean;
  logic [IVW-1:0]  amount, shrunk, grown;
  logic [IVW:0]    floor_sum, grow_sum;

  assign ovf1   = word_i[aric_pkg::RANK1_OVF_BIT];
  assign ovf0   = word_i[aric_pkg::RANK0_OVF_BIT];
  assign cnt1_o = word_i[aric_pkg::RANK1_LSB +: COUNT_BITS];
  assign cnt0_o = word_i[aric_pkg::RANK0_LSB +: COUNT_BITS];

  assign clean = !ovf1 && !ovf0 && (prev1_i >= cnt1_o) && (prev0_i >= cnt0_o);

  // decrease by twice the step, clamp at the floor
  assign amount    = {cfg_i.dec_step, 1'b0};
  assign floor_sum = {1'b0, cfg_i.min_iv} + {1'b0, amount};
  assign shrunk    = ({1'b0, iv_i} < floor_sum) ? cfg_i.min_iv : iv_i - amount;

  // increase saturates at the field maximum
  assign grow_sum = {1'b0, iv_i} + {1'b0, cfg_i.inc_step};
  assign grown    = grow_sum[IVW] ? aric_pkg::IV_MAX : grow_sum[IVW-1:0];

  always_comb begin
    flags_o = flags_i;
    iv_o    = shrunk;
    err_o   = 1'b0;
    if (clean) begin
      if (!flags_i.rank1 && !flags_i.rank0) begin
        iv_o = (iv_i < cfg_i.max_iv) ? grown : iv_i;
      end else if (flags_i.rank1 && (prev1_i > cnt1_o)) begin
        flags_o.rank1 = 1'b0;
      end else if (flags_i.rank0 && (prev0_i > cnt0_o)) begin
        flags_o.rank0 = 1'b0;
      end
    end else begin
      if (ovf1 || (prev1_i < cnt1_o)) flags_o.rank1 = 1'b1;
      if (ovf0 || (prev0_i < cnt0_o)) flags_o.rank0 = 1'b1;
      err_o = 1'b1;
    end
  end

endmodule

@@ hw/rtl/adaptive_refresh_interval_ctrl.sv @@
`timescale 1ns / 1ps

// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+------------------------------------------
// poll in  | sink      | in_valid_i / in_stall_o | error_word_i, present_interval_i
// result   | source    | out_valid_o / out_stall_i| channel_index_o, new_interval_o, error_seen_o
// config   | apb       | psel, penable, pwrite   | paddr, pwdata, prdata, pready
//
// a beat is taken one per cycle while the result side is not stalled; each poll lands in the input register
// when accepted and then in the result register, the update between them being combinational
// reset clears the channel pointer, stored counts, flags and both valid stages; the
// config registers return to their documented defaults
// a stalled result holds the input register, which then stalls the poll side

module adaptive_refresh_interval_ctrl #(
  parameter int unsigned NUM_CHANNELS = 4,
  parameter int unsigned COUNT_BITS   = 15
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // poll beats
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [aric_pkg::WORD_W-1:0]  error_word_i,
  input  logic [aric_pkg::IV_W-1:0]    present_interval_i,
  // result beats
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   channel_index_o,
  output logic [aric_pkg::IV_W-1:0]    new_interval_o,
  output logic                         error_seen_o,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [aric_pkg::ADDR_W-1:0]  paddr,
  input  logic [aric_pkg::DATA_W-1:0]  pwdata,
  output logic [aric_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int unsigned PTR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  aric_pkg::cfg_t cfg;

  // input register
  logic                         in_vld_q;
  logic [aric_pkg::WORD_W-1:0]  word_q;
  logic [aric_pkg::IV_W-1:0]    iv_q;

  // result register
  logic                         out_vld_q;
  logic [1:0]                   ch_q;
  logic [aric_pkg::IV_W-1:0]    new_iv_q;
  logic                         err_q;

  logic                         in_take, advance;

  // per-channel history
  logic [PTR_W-1:0]             ch;
  logic [PTR_W+1:0]             ch_ext;
  logic [COUNT_BITS-1:0]        prev1, prev0, cnt1, cnt0;
  aric_pkg::flags_t             flags_cur, flags_nxt;

  // update result
  logic [aric_pkg::IV_W-1:0]    new_iv;
  logic                         err;

  aric_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // the item in the input register moves on when the result register is free or drains
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  aric_chan_state #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_state (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (advance),
    .cnt1_i  (cnt1),
    .cnt0_i  (cnt0),
    .flags_i (flags_nxt),
    .ch_o    (ch),
    .cnt1_o  (prev1),
    .cnt0_o  (prev0),
    .flags_o (flags_cur)
  );

  aric_update #(
    .COUNT_BITS (COUNT_BITS)
  ) u_update (
    .cfg_i   (cfg),
    .word_i  (word_q),
    .iv_i    (iv_q),
    .prev1_i (prev1),
    .prev0_i (prev0),
    .flags_i (flags_cur),
    .cnt1_o  (cnt1),
    .cnt0_o  (cnt0),
    .flags_o (flags_nxt),
    .iv_o    (new_iv),
    .err_o   (err)
  );

  // channel number reported on two bits
  assign ch_ext = {2'b00, ch};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      word_q <= error_word_i;
      iv_q   <= present_interval_i;
    end
    if (advance) begin
      ch_q     <= ch_ext[1:0];
      new_iv_q <= new_iv;
      err_q    <= err;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign channel_index_o = ch_q;
  assign new_interval_o  = new_iv_q;
  assign error_seen_o    = err_q;

endmodule

@@ hw/rtl/aric_checker.sv @@
`timescale 1ns / 1ps

module aric_checker #(
  parameter int unsigned NUM_CHANNELS = 4
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [1:0]                  channel_index_o,
  input logic [aric_pkg::IV_W-1:0]   new_interval_o,
  input logic                        error_seen_o,
  input logic                        pready
);

  localparam int unsigned PTR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [PTR_W-1:0] exp_ch_q;
  logic [PTR_W+1:0] exp_ext;

  assign exp_ext = {2'b00, exp_ch_q};

  // expected channel of the next result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_ch_q <= '0;
    end else if (out_valid_o && !out_stall_i) begin
      exp_ch_q <= (exp_ch_q == PTR_W'(NUM_CHANNELS - 1)) ? '0 : exp_ch_q + 1'b1;
    end
  end

  a_round_robin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> channel_index_o == exp_ext[1:0])
    else $error("result channel out of round robin order");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(channel_index_o)
      && $stable(new_interval_o) && $stable(error_seen_o))
    else $error("stalled result beat changed");

  a_no_stall_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("poll side stalled with empty result register");

  a_reset_quiet : assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o && pready)
    else $error("result valid during reset");

  a_take_reaches_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> ##1 out_valid_o)
    else $error("accepted poll did not reach the result register");

endmodule

bind adaptive_refresh_interval_ctrl aric_checker #(
  .NUM_CHANNELS (NUM_CHANNELS)
) u_aric_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .channel_index_o (channel_index_o),
  .new_interval_o  (new_interval_o),
  .error_seen_o    (error_seen_o),
  .pready          (pready)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned N_CH        = 4;
  localparam int unsigned CNT_W       = 15;
  localparam int unsigned PHASE_POLLS = 260;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned N_DIRECTED  = 20;

  localparam int unsigned WORD_W = aric_pkg::WORD_W;
  localparam int unsigned IV_W   = aric_pkg::IV_W;
  localparam int unsigned INC_W  = aric_pkg::INC_W;
  localparam int unsigned DEC_W  = aric_pkg::DEC_W;
  localparam int unsigned ADDR_W = aric_pkg::ADDR_W;
  localparam int unsigned DATA_W = aric_pkg::DATA_W;

  // one write-back beat as it leaves the block
  typedef struct packed {
    logic [1:0]      chan;
    logic [IV_W-1:0] interval;
    logic            err;
  } refresh_update_t;

  // keeps its own copy of the per-channel history and works out each write-back
  class refresh_scoreboard;
    logic [INC_W-1:0] inc_step;
    logic [DEC_W-1:0] dec_step;
    logic [IV_W-1:0]  max_iv;
    logic [IV_W-1:0]  min_iv;
    int unsigned      poll_ch;
    logic [CNT_W-1:0] cnt1 [N_CH];
    logic [CNT_W-1:0] cnt0 [N_CH];
    logic             flag1 [N_CH];
    logic             flag0 [N_CH];
    logic [IV_W-1:0]  last_iv [N_CH];
    refresh_update_t  expected_updates [$];
    int unsigned      failures;

    function new();
      inc_step = aric_pkg::INC_STEP_RST;
      dec_step = aric_pkg::DEC_STEP_RST;
      max_iv   = aric_pkg::MAX_IV_RST;
      min_iv   = aric_pkg::MIN_IV_RST;
      poll_ch  = 0;
      failures = 0;
      for (int i = 0; i < N_CH; i++) begin
        cnt1[i] = '0; cnt0[i] = '0; flag1[i] = 1'b0; flag0[i] = 1'b0; last_iv[i] = '0;
      end
    endfunction

    function void set_reg(aric_pkg::reg_idx_e idx, logic [DATA_W-1:0] val);
      case (idx)
        aric_pkg::REG_INC_STEP: inc_step = val[INC_W-1:0];
        aric_pkg::REG_DEC_STEP: dec_step = val[DEC_W-1:0];
        aric_pkg::REG_MAX_IV:   max_iv   = val[IV_W-1:0];
        aric_pkg::REG_MIN_IV:   min_iv   = val[IV_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned shrunk(int unsigned iv);
      int unsigned amount;
      amount = 2 * dec_step;
      if (iv < min_iv + amount) return 32'(min_iv);
      return iv - amount;
    endfunction

    function int unsigned pending();
      return expected_updates.size();
    endfunction

    function void note_poll(logic [WORD_W-1:0] word, logic [IV_W-1:0] iv_in);
      logic             ovf1, ovf0, f1, f0;
      logic [CNT_W-1:0] c1, c0, p1, p0;
      int unsigned      iv;
      refresh_update_t  upd;
      ovf1 = word[aric_pkg::RANK1_OVF_BIT];
      ovf0 = word[aric_pkg::RANK0_OVF_BIT];
      c1   = word[aric_pkg::RANK1_LSB +: CNT_W];
      c0   = word[aric_pkg::RANK0_LSB +: CNT_W];
      p1   = cnt1[poll_ch];
      p0   = cnt0[poll_ch];
      f1   = flag1[poll_ch];
      f0   = flag0[poll_ch];
      iv   = 32'(iv_in);
      upd.err = 1'b0;
      if (!ovf1 && !ovf0 && p1 >= c1 && p0 >= c0) begin
        if (!f1 && !f0) begin
          if (iv < max_iv) begin
            iv = iv + inc_step;
            if (iv > aric_pkg::IV_MAX) iv = 32'(aric_pkg::IV_MAX);
          end
        end else if (p1 > c1 && f1) begin
          f1 = 1'b0;
          iv = shrunk(iv);
        end else if (p0 > c0 && f0) begin
          f0 = 1'b0;
          iv = shrunk(iv);
        end else begin
          iv = shrunk(iv);
        end
      end else begin
        if (ovf1 || p1 < c1) f1 = 1'b1;
        if (ovf0 || p0 < c0) f0 = 1'b1;
        iv = shrunk(iv);
        upd.err = 1'b1;
      end
      upd.chan     = poll_ch[1:0];
      upd.interval = iv[IV_W-1:0];
      cnt1[poll_ch]    = c1;
      cnt0[poll_ch]    = c0;
      flag1[poll_ch]   = f1;
      flag0[poll_ch]   = f0;
      last_iv[poll_ch] = upd.interval;
      poll_ch = (poll_ch + 1 >= N_CH) ? 0 : poll_ch + 1;
      expected_updates.push_back(upd);
    endfunction

    function void check_result(refresh_update_t got);
      refresh_update_t want;
      if (expected_updates.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result beat: ch %0d iv %0d err %0d",
                   got.chan, got.interval, got.err);
        return;
      end
      want = expected_updates.pop_front();
      if (got.chan != want.chan || got.interval != want.interval || got.err != want.err) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected ch %0d iv %0d err %0d, got ch %0d iv %0d err %0d",
                   want.chan, want.interval, want.err, got.chan, got.interval, got.err);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [WORD_W-1:0]   error_word_i;
  logic [IV_W-1:0]     present_interval_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [1:0]          channel_index_o;
  logic [IV_W-1:0]     new_interval_o;
  logic                error_seen_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  refresh_scoreboard sb = new();

  // shared knobs between the stimulus thread and the result-side thread
  bit          calm;          // no random idling on either side
  bit          hold_trigger;  // asks the result side for a long hold-off
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  // directed polls, in channel order A, B, C, D, A, ...
  logic [WORD_W-1:0] dir_word [N_DIRECTED] = '{
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,  // clean: below, at, top, just below max
    32'h8000_0000, 32'h0000_8000, 32'h7fff_7fff, 32'h0001_0000,  // overflows and count rises
    32'h0000_0000, 32'h0000_0000, 32'h1234_0abc, 32'h0000_0000,  // flags held, both flagged drop, rank 1 drop
    32'h0000_0000, 32'h0000_0000, 32'h1234_0001, 32'h0000_0000,  // flag still set, rank 0 drop, clean again
    32'hffff_ffff, 32'h0000_0005, 32'h0000_0003, 32'h0000_0000
  };
  logic [IV_W-1:0] dir_iv [N_DIRECTED] = '{
    15'd0,     15'd29120, 15'd32767, 15'd29119,
    15'd100,   15'd20,    15'd32767, 15'd5000,
    15'd200,   15'd31,    15'd1000,  15'd40,
    15'd0,     15'd32767, 15'd600,   15'd700,
    15'd0,     15'd29121, 15'd32766, 15'd1
  };

  adaptive_refresh_interval_ctrl #(
    .NUM_CHANNELS(N_CH),
    .COUNT_BITS  (CNT_W)
  ) i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .error_word_i      (error_word_i),
    .present_interval_i(present_interval_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .channel_index_o   (channel_index_o),
    .new_interval_o    (new_interval_o),
    .error_seen_o      (error_seen_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog on total run length
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // both handshakes are sampled here, before this edge's updates land
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_poll(error_word_i, present_interval_i);
      if (out_valid_o && !out_stall_i)
        sb.check_result('{chan: channel_index_o, interval: new_interval_o, err: error_seen_o});
    end
  end

  // result side: random stall, or a long counted hold-off when asked
  always @(posedge clk_i) begin
    if (hold_trigger) begin
      hold_trigger = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(0, 99) < 33);
    end
  end

  // offer one poll beat, idling at random first, and return once it is taken
  task automatic send_poll(input logic [WORD_W-1:0] word, input logic [IV_W-1:0] iv);
    while (!calm && $urandom_range(0, 99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    error_word_i       <= word;
    present_interval_i <= iv;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // let every outstanding write-back come out, plus a little slack for the pipe
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // setup then access phase; the register takes the value on the access edge
  task automatic write_reg(input aric_pkg::reg_idx_e idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_phase_regs(input int phase);
    logic [INC_W-1:0] inc;
    logic [DEC_W-1:0] dec;
    logic [IV_W-1:0]  hi, lo;
    inc = INC_W'($urandom_range(0, 32767));
    dec = DEC_W'($urandom_range(0, 16383));
    hi  = IV_W'($urandom_range(0, 32767));
    lo  = IV_W'($urandom_range(0, 8000));
    case (phase)
      0: begin inc = 15'd32767; dec = 14'd16383; hi = 15'd32767; lo = 15'd0;     end
      1: begin inc = 15'd0;     dec = 14'd0;     hi = 15'd0;     lo = 15'd32767; end
      2: begin inc = 15'd1;     dec = 14'd1;     hi = 15'd32767; lo = 15'd0;     end
      4: begin inc = 15'd100;   dec = 14'd50;    hi = 15'd20000; lo = 15'd5000;  end
      6: begin inc = 15'd16;    dec = 14'd16;    hi = 15'd29120; lo = 15'd0;     end
      default: ;  // random setting
    endcase
    write_reg(aric_pkg::REG_INC_STEP, DATA_W'(inc));
    write_reg(aric_pkg::REG_DEC_STEP, DATA_W'(dec));
    write_reg(aric_pkg::REG_MAX_IV,   DATA_W'(hi));
    write_reg(aric_pkg::REG_MIN_IV,   DATA_W'(lo));
  endtask

  // mostly plausible counter histories: counts hold or fall, sometimes climb or overflow
  function automatic logic [WORD_W-1:0] pick_word(int unsigned ch);
    logic [CNT_W-1:0] c1, c0;
    logic             o1, o0;
    int unsigned      kind;
    c1   = sb.cnt1[ch];
    c0   = sb.cnt0[ch];
    o1   = 1'b0;
    o0   = 1'b0;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      if ($urandom_range(0, 1)) c1 = CNT_W'($urandom_range(0, c1));
      if ($urandom_range(0, 1)) c0 = CNT_W'($urandom_range(0, c0));
    end else if (kind < 75) begin
      if ($urandom_range(0, 1) && c1 < 15'd32700) c1 = CNT_W'(c1 + $urandom_range(1, 60));
      if ($urandom_range(0, 1) && c0 < 15'd32700) c0 = CNT_W'(c0 + $urandom_range(1, 60));
    end else if (kind < 85) begin
      o1 = 1'($urandom_range(0, 1));
      o0 = !o1 || $urandom_range(0, 1);
      c1 = CNT_W'($urandom_range(0, 32767));
      c0 = CNT_W'($urandom_range(0, 32767));
    end else begin
      return $urandom();
    end
    return {o1, c1, o0, c0};
  endfunction

  // usually the interval last written back, as software would read it
  function automatic logic [IV_W-1:0] pick_interval(int unsigned ch);
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 70) return sb.last_iv[ch];
    if (kind < 85) return IV_W'($urandom_range(0, 32767));
    case ($urandom_range(0, 4))
      0: return '0;
      1: return aric_pkg::IV_MAX;
      2: return sb.max_iv;
      3: return sb.min_iv;
      default: return sb.max_iv - 1'b1;
    endcase
  endfunction

  initial begin
    int unsigned ch;
    in_valid_i         = 1'b0;
    error_word_i       = '0;
    present_interval_i = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    calm               = 1'b0;
    hold_trigger       = 1'b0;
    rst_ni             = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed polls under the reset register values
    for (int i = 0; i < N_DIRECTED; i++) send_poll(dir_word[i], dir_iv[i]);
    ch = N_DIRECTED % N_CH;

    for (int phase = 0; phase < 7; phase++) begin
      in_valid_i <= 1'b0;
      wait_drained();
      set_phase_regs(phase);
      calm = (phase == 3);
      for (int n = 0; n < PHASE_POLLS; n++) begin
        // long result-side hold-off while polls keep coming, so the input backs up
        if (phase == 0 && n == 60) hold_trigger = 1'b1;
        // poll side goes quiet until every write-back is out
        if (phase == 5 && n == 130) begin
          in_valid_i <= 1'b0;
          wait_drained();
        end
        send_poll(pick_word(ch), pick_interval(ch));
        ch = (ch + 1) % N_CH;
      end
    end

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
